// ----- src/gda_pkg.sv -----
// shared types, constants and calendar helpers for the date arithmetic unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package gda_pkg;
    localparam int COUNT_BITS = 20;
    localparam int DN_BITS    = 22;
    localparam int DIFF_BITS  = 23;
    localparam logic [DN_BITS-1:0] LAST_DAYNUM = 22'd3652058;
    localparam logic [17:0] DAYS_400Y = 18'd146097;
    localparam logic [15:0] DAYS_100Y = 16'd36524;
    localparam logic [10:0] DAYS_4Y   = 11'd1461;

    localparam logic [1:0] ACT_ADD  = 2'd0;
    localparam logic [1:0] ACT_SUB  = 2'd1;
    localparam logic [1:0] ACT_DIFF = 2'd2;
    // unused action code, always flagged as an error
    localparam logic [1:0] ACT_NONE = 2'd3;

    // cumulative days before month, non-leap
    function automatic logic [8:0] f_cum(input logic [3:0] m);
        logic [8:0] r;
        unique case (m)
            4'd1: r = 9'd0;    4'd2: r = 9'd31;   4'd3: r = 9'd59;
            4'd4: r = 9'd90;   4'd5: r = 9'd120;  4'd6: r = 9'd151;
            4'd7: r = 9'd181;  4'd8: r = 9'd212;  4'd9: r = 9'd243;
            4'd10: r = 9'd273; 4'd11: r = 9'd304; 4'd12: r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] f_mlen(input logic [3:0] m, input logic leap);
        logic [4:0] r;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
            4'd2: r = leap ? 5'd29 : 5'd28;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    // quotient by 100 through a reciprocal multiply, exact for any 14-bit value
    function automatic logic [7:0] f_div100(input logic [13:0] v);
        logic [27:0] prod;
        prod = 28'(v) * 28'd5243;
        return 8'(prod >> 19);
    endfunction

    // leap from the quotient by 100: divisible by 400 when the century
    // count is a multiple of four and nothing is left over
    function automatic logic f_leap(input logic [13:0] y);
        logic [7:0]  q100;
        logic [13:0] back;
        q100 = f_div100(y);
        back = 14'(q100) * 14'd100;
        return (y[1:0] == 2'd0) && ((back != y) || (q100[1:0] == 2'd0));
    endfunction

    typedef struct packed {
        logic        vld;
        logic [1:0]  act;
        logic        err;
        logic [DN_BITS-1:0] na;
        logic [DN_BITS-1:0] nb;
        logic [COUNT_BITS-1:0] cnt;
    } t_dn;

    typedef struct packed {
        logic [13:0] y;
        logic [3:0]  m;
        logic [4:0]  d;
        logic [DIFF_BITS-1:0] diff;
        logic        gt;
        logic        eq;
        logic        err;
    } t_res;
endpackage
`default_nettype wire

// ----- src/gregorian_date_arithmetic.sv -----
// top level of the gregorian date arithmetic unit
// depends on gda_pkg, gda_to_dn, gda_from_dn
//
// usage: one input word (action, date a, day count, date b) gives exactly
// one output word. add and subtract move date a by the count; difference
// gives days from b to a with greater and equal flags. an invalid date a,
// an invalid date b for difference, action 3 and results outside years
// 1..9999 raise range_error with all other fields zero.
// pipeline of five register stages: one for date to day number, one for
// the add, subtract or compare, three for day number back to a date.
// one word may enter every cycle while o_stall is low.
// a stall from the receiver freezes the whole pipeline, so o_stall
// follows i_stall exactly while the output holds a word; no word is lost
// or repeated. reset clears the stage valid bits only.
`timescale 1ns / 1ps
`default_nettype none
module gregorian_date_arithmetic
    import gda_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [13:0] i_year_a,
    input  wire logic [3:0]  i_month_a,
    input  wire logic [4:0]  i_day_a,
    input  wire logic [19:0] i_day_count,
    input  wire logic [13:0] i_year_b,
    input  wire logic [3:0]  i_month_b,
    input  wire logic [4:0]  i_day_b,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [13:0]      o_res_year,
    output logic [3:0]       o_res_month,
    output logic [4:0]       o_res_day,
    output logic signed [22:0] o_day_difference,
    output logic             o_a_greater,
    output logic             o_dates_equal,
    output logic             o_range_error
);
    localparam int NS = 5;
    logic          en;
    logic [NS-1:0] r_vld;
    logic [1:0]    r_act;
    logic [COUNT_BITS-1:0] r_cnt;
    logic          ok_a, ok_b;
    logic [DN_BITS-1:0] dn_a, dn_b;
    t_res          r_s3, n_s3;
    t_res          r_s4, r_s5, r_s6;
    logic [DN_BITS-1:0] r_nr, n_nr;
    logic          r_nrv, n_nrv;
    logic [DN_BITS:0] sum;
    logic [13:0]   fy;
    logic [3:0]    fm;
    logic [4:0]    fd;
    logic          r_dv [3];

    assign en      = !(r_vld[NS-1] && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    gda_to_dn u_a (.i_clk(i_clk), .i_en(en), .i_year(i_year_a), .i_month(i_month_a),
                   .i_day(i_day_a), .o_ok(ok_a), .o_dn(dn_a));
    gda_to_dn u_b (.i_clk(i_clk), .i_en(en), .i_year(i_year_b), .i_month(i_month_b),
                   .i_day(i_day_b), .o_ok(ok_b), .o_dn(dn_b));

    // dn outputs are valid after one stage; act and count delayed to match
    always_comb begin
        n_s3  = '0;
        n_nr  = '0;
        n_nrv = 1'b0;
        sum   = '0;
        if (r_act == ACT_DIFF) begin
            if (!ok_a || !ok_b) begin
                n_s3.err = 1'b1;
            end else begin
                n_s3.diff = DIFF_BITS'(dn_a) - DIFF_BITS'(dn_b);
                n_s3.gt   = dn_a > dn_b;
                n_s3.eq   = dn_a == dn_b;
            end
        end else if (r_act == ACT_ADD || r_act == ACT_SUB) begin
            if (!ok_a) begin
                n_s3.err = 1'b1;
            end else if (r_act == ACT_ADD) begin
                sum = (DN_BITS+1)'(dn_a) + (DN_BITS+1)'(r_cnt);
                if (sum > (DN_BITS+1)'(LAST_DAYNUM)) n_s3.err = 1'b1;
                else begin n_nr = DN_BITS'(sum); n_nrv = 1'b1; end
            end else begin
                if (DN_BITS'(r_cnt) > dn_a) n_s3.err = 1'b1;
                else begin n_nr = dn_a - DN_BITS'(r_cnt); n_nrv = 1'b1; end
            end
        end else begin
            n_s3.err = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_act    <= i_action;
            r_cnt    <= i_day_count[COUNT_BITS-1:0];
            r_s3     <= n_s3;
            r_nr     <= n_nr;
            r_nrv    <= n_nrv;
            r_s4     <= r_s3;
            r_s5     <= r_s4;
            r_s6     <= r_s5;
            r_dv[0]  <= r_nrv;
            r_dv[1]  <= r_dv[0];
            r_dv[2]  <= r_dv[1];
        end
    end

    // from_dn has three register stages; side data goes through three registers to match
    gda_from_dn u_fd (.i_clk(i_clk), .i_en(en), .i_dn(r_nr),
                      .o_year(fy), .o_month(fm), .o_day(fd));

    assign o_valid          = r_vld[NS-1];
    assign o_res_year       = r_dv[2] ? fy : 14'd0;
    assign o_res_month      = r_dv[2] ? fm : 4'd0;
    assign o_res_day        = r_dv[2] ? fd : 5'd0;
    assign o_day_difference = r_s6.diff;
    assign o_a_greater      = r_s6.gt;
    assign o_dates_equal    = r_s6.eq;
    assign o_range_error    = r_s6.err;
endmodule
`default_nettype wire

// ----- src/gda_to_dn.sv -----
// date to day number conversion in one register stage, with validity check
// depends on gda_pkg
`timescale 1ns / 1ps
`default_nettype none
module gda_to_dn
    import gda_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [13:0] i_year,
    input  wire logic [3:0]  i_month,
    input  wire logic [4:0]  i_day,
    output logic             o_ok,
    output logic [DN_BITS-1:0] o_dn
);
    logic [DN_BITS-1:0] r_base, n_base;
    logic [8:0]  r_doy, n_doy;
    logic        r_ok, n_ok;
    logic [13:0] p;
    logic [7:0]  q100;
    logic        leap;

    always_comb begin
        p      = i_year - 14'd1;
        q100   = f_div100(p);
        leap   = f_leap(i_year);
        n_base = DN_BITS'(p * 22'd365) + DN_BITS'(p >> 2)
               - DN_BITS'(q100) + DN_BITS'(q100 >> 2);
        n_doy  = f_cum(i_month) + 9'((leap && i_month > 4'd2) ? 1 : 0)
               + 9'(i_day) - 9'd1;
        n_ok   = (i_year >= 14'd1) && (i_year <= 14'd9999)
               && (i_month >= 4'd1) && (i_month <= 4'd12)
               && (i_day >= 5'd1) && (i_day <= f_mlen(i_month, leap));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_base <= n_base;
            r_doy  <= n_doy;
            r_ok   <= n_ok;
        end
    end

    assign o_ok = r_ok;
    assign o_dn = r_base + DN_BITS'(r_doy);
endmodule
`default_nettype wire

// ----- src/gda_from_dn.sv -----
// three-stage day number to date conversion
// depends on gda_pkg
`timescale 1ns / 1ps
`default_nettype none
module gda_from_dn
    import gda_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [DN_BITS-1:0] i_dn,
    output logic [13:0]      o_year,
    output logic [3:0]       o_month,
    output logic [4:0]       o_day
);
    // stage 1: 400 and 100 year cycles
    logic [4:0]  r_q400, n_q400;
    logic [1:0]  r_q100, n_q100;
    logic [15:0] r_r1, n_r1;
    // stage 2: 4 year and single years
    logic [13:0] r_y, n_y;
    logic [8:0]  r_doy, n_doy;
    logic [4:0]  q400e;
    logic [18:0] remw;
    logic [17:0] rem;
    logic [4:0]  q4e;
    logic [11:0] r4w;
    logic [4:0]  q4;
    logic [10:0] r4;
    logic [1:0]  q1;
    logic [3:0]  mo;
    logic [8:0]  cm;
    logic        leap;

    always_comb begin
        // reciprocal estimate is the quotient or one below, fixed by one compare
        q400e  = 5'((27'(i_dn) * 27'd28) >> 22);
        remw   = 19'(i_dn - DN_BITS'(q400e) * DN_BITS'(DAYS_400Y));
        n_q400 = (remw >= 19'(DAYS_400Y)) ? q400e + 5'd1 : q400e;
        rem    = (remw >= 19'(DAYS_400Y)) ? 18'(remw - 19'(DAYS_400Y)) : 18'(remw);
        n_q100 = (rem >= 18'(3 * 36524)) ? 2'd3 : (rem >= 18'(2 * 36524)) ? 2'd2
               : (rem >= 18'(36524)) ? 2'd1 : 2'd0;
        n_r1   = 16'(rem - 18'(n_q100) * 18'(DAYS_100Y));

        q4e    = 5'((21'(r_r1) * 21'd44) >> 16);
        r4w    = 12'(r_r1 - 16'(q4e) * 16'(DAYS_4Y));
        q4     = (r4w >= 12'(DAYS_4Y)) ? q4e + 5'd1 : q4e;
        r4     = (r4w >= 12'(DAYS_4Y)) ? 11'(r4w - 12'(DAYS_4Y)) : 11'(r4w);
        q1     = (r4 >= 11'd1095) ? 2'd3 : (r4 >= 11'd730) ? 2'd2
               : (r4 >= 11'd365) ? 2'd1 : 2'd0;
        n_doy  = 9'(r4 - 11'(q1) * 11'd365);
        n_y    = 14'(r_q400) * 14'd400 + 14'(r_q100) * 14'd100
               + 14'(q4) * 14'd4 + 14'(q1) + 14'd1;

        leap   = f_leap(r_y);
        mo     = 4'd1;
        for (int k = 2; k <= 12; k++) begin
            if (r_doy >= f_cum(4'(k)) + 9'((leap && k > 2) ? 1 : 0)) mo = 4'(k);
        end
        cm     = f_cum(mo) + 9'((leap && mo > 4'd2) ? 1 : 0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q400 <= n_q400;
            r_q100 <= n_q100;
            r_r1   <= n_r1;
            r_y    <= n_y;
            r_doy  <= n_doy;
            o_year <= r_y;
            o_month <= mo;
            o_day  <= 5'(r_doy - cm + 9'd1);
        end
    end
endmodule
`default_nettype wire

// ----- tb/gregorian_date_arithmetic_test.sv -----
// testbench for the gregorian date arithmetic unit: directed and random words,
// a calendar predictor and an in-order scoreboard
// depends on gda_pkg and gregorian_date_arithmetic
`timescale 1ns / 1ps
`default_nettype none

class date_result_board;
    typedef struct {
        logic [13:0] y;
        logic [3:0]  m;
        logic [4:0]  d;
        logic [22:0] diff;
        logic        gt;
        logic        eq;
        logic        err;
    } t_date_result;

    t_date_result pending[$];
    int           mismatches;

    function new();
        mismatches = 0;
    endfunction

    static function bit leap_year(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    static function int unsigned month_days(int unsigned y, int unsigned m);
        int unsigned len[13];
        len = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m < 1 || m > 12) return 0;
        return len[m] + ((m == 2 && leap_year(y)) ? 1 : 0);
    endfunction

    static function bit date_valid(int unsigned y, int unsigned m, int unsigned d);
        return y >= 1 && y <= 9999 && m >= 1 && m <= 12
            && d >= 1 && d <= month_days(y, m);
    endfunction

    static function int unsigned day_number(int unsigned y, int unsigned m,
                                            int unsigned d);
        int unsigned p;
        int unsigned n;
        p = y - 1;
        n = 365 * p + p / 4 - p / 100 + p / 400;
        for (int unsigned k = 1; k < m; k++) n += month_days(y, k);
        return n + d - 1;
    endfunction

    // walk whole years from a 400-year anchor, then months
    static function void calendar_date(int unsigned n, output int unsigned y,
                                       output int unsigned m, output int unsigned d);
        int unsigned r;
        int unsigned ylen;
        y = (n / 146097) * 400 + 1;
        r = n % 146097;
        ylen = leap_year(y) ? 366 : 365;
        while (r >= ylen) begin
            r -= ylen;
            y++;
            ylen = leap_year(y) ? 366 : 365;
        end
        m = 1;
        while (r >= month_days(y, m)) begin
            r -= month_days(y, m);
            m++;
        end
        d = r + 1;
    endfunction

    function void note_word(logic [1:0] act, logic [13:0] ya, logic [3:0] ma,
                            logic [4:0] da, logic [19:0] cnt, logic [13:0] yb,
                            logic [3:0] mb, logic [4:0] db);
        t_date_result e;
        int unsigned  na, nb, y, m, d;
        longint       nr;
        e = '{default: '0};
        if (act == gda_pkg::ACT_NONE || !date_valid(ya, ma, da)) begin
            e.err = 1;
        end else if (act == gda_pkg::ACT_DIFF) begin
            if (!date_valid(yb, mb, db)) begin
                e.err = 1;
            end else begin
                na = day_number(ya, ma, da);
                nb = day_number(yb, mb, db);
                e.diff = 23'(int'(na) - int'(nb));
                e.gt = na > nb;
                e.eq = na == nb;
            end
        end else begin
            na = day_number(ya, ma, da);
            nr = (act == gda_pkg::ACT_ADD) ? longint'(na) + cnt : longint'(na) - cnt;
            if (nr < 0 || nr > 3652058) begin
                e.err = 1;
            end else begin
                calendar_date(int'(nr), y, m, d);
                e.y = 14'(y);
                e.m = 4'(m);
                e.d = 5'(d);
            end
        end
        pending.push_back(e);
    endfunction

    function void check_word(logic [13:0] y, logic [3:0] m, logic [4:0] d,
                             logic [22:0] diff, logic gt, logic eq, logic err);
        t_date_result e;
        if (pending.size() == 0) begin
            $error("unexpected output word");
            mismatches++;
            return;
        end
        e = pending.pop_front();
        if (y !== e.y) begin
            $error("res_year exp %0d got %0d", e.y, y); mismatches++;
        end
        if (m !== e.m) begin
            $error("res_month exp %0d got %0d", e.m, m); mismatches++;
        end
        if (d !== e.d) begin
            $error("res_day exp %0d got %0d", e.d, d); mismatches++;
        end
        if (diff !== e.diff) begin
            $error("day_difference exp %0d got %0d", $signed(e.diff), $signed(diff));
            mismatches++;
        end
        if (gt !== e.gt) begin
            $error("a_greater exp %0b got %0b", e.gt, gt); mismatches++;
        end
        if (eq !== e.eq) begin
            $error("dates_equal exp %0b got %0b", e.eq, eq); mismatches++;
        end
        if (err !== e.err) begin
            $error("range_error exp %0b got %0b", e.err, err); mismatches++;
        end
    endfunction
endclass

module gregorian_date_arithmetic_test;
    import gda_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        i_stall = 0;
    logic [1:0]  i_action = '0;
    logic [13:0] i_year_a = '0, i_year_b = '0;
    logic [3:0]  i_month_a = '0, i_month_b = '0;
    logic [4:0]  i_day_a = '0, i_day_b = '0;
    logic [19:0] i_day_count = '0;
    logic        o_stall, o_valid;
    logic [13:0] o_res_year;
    logic [3:0]  o_res_month;
    logic [4:0]  o_res_day;
    logic signed [22:0] o_day_difference;
    logic        o_a_greater, o_dates_equal, o_range_error;

    date_result_board board = new();

    gregorian_date_arithmetic dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic send_word(logic [1:0] act, logic [13:0] ya, logic [3:0] ma,
                             logic [4:0] da, logic [19:0] cnt, logic [13:0] yb,
                             logic [3:0] mb, logic [4:0] db);
        int g;
        g = gap_len();
        repeat (g) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1;
        i_action <= act;
        i_year_a <= ya; i_month_a <= ma; i_day_a <= da;
        i_day_count <= cnt;
        i_year_b <= yb; i_month_b <= mb; i_day_b <= db;
        do @(posedge i_clk); while (o_stall);
        board.note_word(act, ya, ma, da, cnt, yb, mb, db);
        @(negedge i_clk);
    endtask

    task automatic send_date_pair(logic [1:0] act, int unsigned cnt);
        logic [13:0] ya, yb;
        logic [3:0]  ma, mb;
        int r;
        r = $urandom_range(0, 9);
        ya = (r < 2) ? 14'($urandom) : 14'($urandom_range(1, 9999));
        yb = (r == 3) ? ya : ((r < 2) ? 14'($urandom) : 14'($urandom_range(1, 9999)));
        ma = (r == 1) ? 4'($urandom) : 4'($urandom_range(1, 12));
        mb = (r == 1) ? 4'($urandom) : 4'($urandom_range(1, 12));
        send_word(act, ya, ma,
                  (r == 0) ? 5'($urandom) : 5'($urandom_range(1, 28)),
                  20'(cnt), yb, mb,
                  (r == 0) ? 5'($urandom) : 5'($urandom_range(1, 28)));
    endtask

    // receiver back-pressure
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            g = gap_len();
            i_stall <= (g != 0);
            repeat (g) @(negedge i_clk);
            i_stall <= 0;
            repeat ($urandom_range(0, 20)) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_word(o_res_year, o_res_month, o_res_day, o_day_difference,
                             o_a_greater, o_dates_equal, o_range_error);
    end

    initial begin
        int r;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // directed: extremes, leap rules, each action and error
        send_word(ACT_ADD, 14'd1, 4'd1, 5'd1, 20'd0, 14'd1, 4'd1, 5'd1);
        send_word(ACT_ADD, 14'd9999, 4'd12, 5'd31, 20'd0, 14'd1, 4'd1, 5'd1);
        send_word(ACT_ADD, 14'd9999, 4'd12, 5'd31, 20'd1, 14'd1, 4'd1, 5'd1);
        send_word(ACT_ADD, 14'd1, 4'd1, 5'd1, 20'hFFFFF, 14'd1, 4'd1, 5'd1);
        send_word(ACT_ADD, 14'd2000, 4'd2, 5'd28, 20'd1, 14'd1, 4'd1, 5'd1);
        send_word(ACT_ADD, 14'd1900, 4'd2, 5'd28, 20'd1, 14'd1, 4'd1, 5'd1);
        send_word(ACT_ADD, 14'd2023, 4'd12, 5'd31, 20'd1, 14'd1, 4'd1, 5'd1);
        send_word(ACT_SUB, 14'd1, 4'd1, 5'd1, 20'd1, 14'd1, 4'd1, 5'd1);
        send_word(ACT_SUB, 14'd1, 4'd1, 5'd1, 20'd0, 14'd1, 4'd1, 5'd1);
        send_word(ACT_SUB, 14'd2024, 4'd3, 5'd1, 20'd1, 14'd1, 4'd1, 5'd1);
        send_word(ACT_SUB, 14'd9999, 4'd12, 5'd31, 20'hFFFFF, 14'd1, 4'd1, 5'd1);
        send_word(ACT_DIFF, 14'd9999, 4'd12, 5'd31, 20'd0, 14'd1, 4'd1, 5'd1);
        send_word(ACT_DIFF, 14'd1, 4'd1, 5'd1, 20'd0, 14'd9999, 4'd12, 5'd31);
        send_word(ACT_DIFF, 14'd2000, 4'd2, 5'd29, 20'd0, 14'd2000, 4'd2, 5'd29);
        send_word(ACT_DIFF, 14'd2001, 4'd2, 5'd29, 20'd0, 14'd2000, 4'd1, 5'd1);
        send_word(ACT_DIFF, 14'd2000, 4'd1, 5'd1, 20'd0, 14'd2000, 4'd13, 5'd1);
        send_word(ACT_DIFF, 14'd2000, 4'd1, 5'd1, 20'd0, 14'h3FFF, 4'd15, 5'd31);
        send_word(ACT_ADD, 14'd0, 4'd1, 5'd1, 20'd5, 14'd1, 4'd1, 5'd1);
        send_word(ACT_ADD, 14'd2000, 4'd0, 5'd1, 20'd5, 14'd1, 4'd1, 5'd1);
        send_word(ACT_ADD, 14'd2000, 4'd4, 5'd31, 20'd5, 14'd1, 4'd1, 5'd1);
        send_word(ACT_SUB, 14'd2000, 4'd4, 5'd0, 20'd5, 14'd1, 4'd1, 5'd1);
        send_word(ACT_NONE, 14'd2000, 4'd4, 5'd1, 20'd5, 14'd2000, 4'd4, 5'd1);
        send_word(ACT_NONE, 14'h3FFF, 4'hF, 5'h1F, 20'hFFFFF, 14'h3FFF, 4'hF, 5'h1F);
        for (int i = 0; i < 1530; i++) begin
            r = $urandom_range(0, 99);
            if (r < 35)
                send_date_pair(ACT_ADD, $urandom_range(0, 99) < 20 ? $urandom
                               : $urandom_range(0, 4000));
            else if (r < 70)
                send_date_pair(ACT_SUB, $urandom_range(0, 99) < 20 ? $urandom
                               : $urandom_range(0, 4000));
            else if (r < 97)
                send_date_pair(ACT_DIFF, $urandom);
            else
                send_date_pair(ACT_NONE, $urandom);
        end
        i_valid <= 0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (board.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule

`default_nettype wire

// ----- filelist.f -----
src/gda_pkg.sv
src/gda_to_dn.sv
src/gda_from_dn.sv
src/gregorian_date_arithmetic.sv
tb/gregorian_date_arithmetic_test.sv
